// ===== rtl/core/tdr_pkg.sv =====
// Shared types, constants and register codes of the threshold dilation block.
package tdr_pkg;

	// Defaults of the top-level size parameters
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_ELEM_W = 16;
	localparam int DEF_MAX_ELEM_H = 16;

	// Register field widths
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;
	localparam int ELEM_BITS   = 5;
	localparam int ANCHOR_BITS = 4;
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 3;

	// Register reset values
	localparam logic [IMG_W_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [IMG_H_BITS-1:0]  RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [ELEM_BITS-1:0]   RST_ELEM_WIDTH   = 5'd3;
	localparam logic [ELEM_BITS-1:0]   RST_ELEM_HEIGHT  = 5'd3;
	localparam logic [ANCHOR_BITS-1:0] RST_ANCHOR_X     = 4'd1;
	localparam logic [ANCHOR_BITS-1:0] RST_ANCHOR_Y     = 4'd1;

	localparam logic [7:0] DARK_LIMIT = 8'd10;
	localparam logic       KIND_PIXEL = 1'b0;

	// Output queue
	localparam int OFIFO_DEPTH = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_ELEM_WIDTH   = 3'd2,
		REG_ELEM_HEIGHT  = 3'd3,
		REG_ANCHOR_X     = 3'd4,
		REG_ANCHOR_Y     = 3'd5
	} reg_idx_t;

	// Window read request travelling from control to the window evaluator
	typedef struct packed {
		logic valid;
		logic last;
	} tdr_req_t;

endpackage

// ===== rtl/core/threshold_dilation_rect_window_top.sv =====
// Top level of the threshold dilation block: config registers, output queue, checks.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  kind, pixel_value
//  out      output     out_valid/ out_stall pixel_out, frame_end
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// One transaction per clock in both directions when the output is not stalled.
// A result passes the request register, the registered RAM read and the output
// queue on its way out; the single write port of each store bank sets the
// one-pixel-per-clock rate. Reset is asynchronous; no clearing pass, the stores
// are only read where the current frame has written. in_stall rises once queued
// plus in-flight results (the two in-flight stages) fill the 4-entry output queue.
module threshold_dilation_rect_window_top import tdr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_ELEM_W = DEF_MAX_ELEM_W,
	parameter int MAX_ELEM_H = DEF_MAX_ELEM_H
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [7:0]                pixel_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                pixel_out,
	output logic                      frame_end,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RING = MAX_ELEM_H + 1;
	localparam int SW   = $clog2(RING);
	localparam int DW   = $clog2(MAX_ELEM_W + 1);
	localparam int QPW  = $clog2(OFIFO_DEPTH);

	// configuration registers
	logic [IMG_W_BITS-1:0]  image_width_q;
	logic [IMG_H_BITS-1:0]  image_height_q;
	logic [ELEM_BITS-1:0]   elem_width_q, elem_height_q;
	logic [ANCHOR_BITS-1:0] anchor_x_q, anchor_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			elem_width_q   <= RST_ELEM_WIDTH;
			elem_height_q  <= RST_ELEM_HEIGHT;
			anchor_x_q     <= RST_ANCHOR_X;
			anchor_y_q     <= RST_ANCHOR_Y;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_BITS-1:0];
				REG_ELEM_WIDTH:   elem_width_q   <= cfg_data[ELEM_BITS-1:0];
				REG_ELEM_HEIGHT:  elem_height_q  <= cfg_data[ELEM_BITS-1:0];
				REG_ANCHOR_X:     anchor_x_q     <= cfg_data[ANCHOR_BITS-1:0];
				REG_ANCHOR_Y:     anchor_y_q     <= cfg_data[ANCHOR_BITS-1:0];
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	logic            accept;
	logic            wr_en;
	logic [SW-1:0]   wr_slot;
	logic [CW-1:0]   wr_col;
	logic [7:0]      wr_pix;
	logic [DW-1:0]   wr_dist;
	tdr_req_t        req_s1;
	logic [SW-1:0]   rd_slot_s1;
	logic [CW-1:0]   rd_col_s1, rd_c1_s1;
	logic [DW-1:0]   rd_span_s1;
	logic [RING-1:0] rd_mask_s1;
	logic            res_valid, res_last;
	logic [7:0]      res_pixel;

	assign accept = in_valid && !in_stall;

	tdr_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_ELEM_W (MAX_ELEM_W),
		.MAX_ELEM_H (MAX_ELEM_H)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.kind         (kind),
		.pixel_value  (pixel_value),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.elem_width   (elem_width_q),
		.elem_height  (elem_height_q),
		.anchor_x     (anchor_x_q),
		.anchor_y     (anchor_y_q),
		.wr_en        (wr_en),
		.wr_slot      (wr_slot),
		.wr_col       (wr_col),
		.wr_pix       (wr_pix),
		.wr_dist      (wr_dist),
		.req_s1       (req_s1),
		.rd_slot_s1   (rd_slot_s1),
		.rd_col_s1    (rd_col_s1),
		.rd_c1_s1     (rd_c1_s1),
		.rd_span_s1   (rd_span_s1),
		.rd_mask_s1   (rd_mask_s1)
	);

	tdr_eval #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_ELEM_W (MAX_ELEM_W),
		.MAX_ELEM_H (MAX_ELEM_H)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_slot    (wr_slot),
		.wr_col     (wr_col),
		.wr_pix     (wr_pix),
		.wr_dist    (wr_dist),
		.req_s1     (req_s1),
		.rd_slot_s1 (rd_slot_s1),
		.rd_col_s1  (rd_col_s1),
		.rd_c1_s1   (rd_c1_s1),
		.rd_span_s1 (rd_span_s1),
		.rd_mask_s1 (rd_mask_s1),
		.res_valid  (res_valid),
		.res_last   (res_last),
		.res_pixel  (res_pixel)
	);

	// output queue; the pipeline never stalls, admission is credit based
	logic [7:0]   q_pix_q  [OFIFO_DEPTH];
	logic         q_last_q [OFIFO_DEPTH];
	logic [QPW-1:0] q_wr_q, q_rd_q;
	logic [QPW:0]   q_cnt_q;
	logic [QPW+1:0] q_load;
	logic           pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (q_cnt_q != '0);
	assign pixel_out = q_pix_q[q_rd_q];
	assign frame_end = q_last_q[q_rd_q];

	// queued plus in-flight results
	assign q_load   = (QPW+2)'(q_cnt_q) + (QPW+2)'(req_s1.valid) + (QPW+2)'(res_valid);
	assign in_stall = (q_load >= (QPW+2)'(OFIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (res_valid) begin
				q_wr_q <= q_wr_q + QPW'(1);
			end
			if (pop) begin
				q_rd_q <= q_rd_q + QPW'(1);
			end
			q_cnt_q <= q_cnt_q + (QPW+1)'(res_valid) - (QPW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			q_pix_q[q_wr_q]  <= res_pixel;
			q_last_q[q_wr_q] <= res_last;
		end
	end

	// a result never arrives at a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (q_cnt_q < (QPW+1)'(OFIFO_DEPTH) || pop))
		else $error("output queue overflow");

	// credits cover every queued and in-flight result
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_load <= (QPW+2)'(OFIFO_DEPTH))
		else $error("in-flight results exceed queue space");

	// every window covers at least its own row
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		req_s1.valid |-> (rd_mask_s1 != '0))
		else $error("empty window row mask");

	// a frame-end request comes out of the evaluator in the next cycle
	a_last_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(req_s1.valid && req_s1.last) |=> (res_valid && res_last))
		else $error("frame end lost in evaluator");

endmodule

// ===== rtl/core/tdr_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module tdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first on address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/tdr_ctrl.sv =====
// Frame geometry, input/output raster counters, store writes and window requests.
module tdr_ctrl import tdr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_ELEM_W = DEF_MAX_ELEM_W,
	parameter int MAX_ELEM_H = DEF_MAX_ELEM_H,
	localparam int CW   = $clog2(MAX_WIDTH),
	localparam int RING = MAX_ELEM_H + 1,
	localparam int SW   = $clog2(RING),
	localparam int DW   = $clog2(MAX_ELEM_W + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   kind,
	input  logic [7:0]             pixel_value,
	input  logic [IMG_W_BITS-1:0]  image_width,
	input  logic [IMG_H_BITS-1:0]  image_height,
	input  logic [ELEM_BITS-1:0]   elem_width,
	input  logic [ELEM_BITS-1:0]   elem_height,
	input  logic [ANCHOR_BITS-1:0] anchor_x,
	input  logic [ANCHOR_BITS-1:0] anchor_y,
	output logic                   wr_en,
	output logic [SW-1:0]          wr_slot,
	output logic [CW-1:0]          wr_col,
	output logic [7:0]             wr_pix,
	output logic [DW-1:0]          wr_dist,
	output tdr_req_t               req_s1,
	output logic [SW-1:0]          rd_slot_s1,
	output logic [CW-1:0]          rd_col_s1,
	output logic [CW-1:0]          rd_c1_s1,
	output logic [DW-1:0]          rd_span_s1,
	output logic [RING-1:0]        rd_mask_s1
);

	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int EXW = (MAX_ELEM_W > 1) ? $clog2(MAX_ELEM_W) : 1;
	localparam int EYW = (MAX_ELEM_H > 1) ? $clog2(MAX_ELEM_H) : 1;
	localparam logic [DW-1:0] DSAT = DW'(MAX_ELEM_W);

	// latched geometry
	logic [CW-1:0]  w_m1_q, fr_w_m1, cur_w_m1;
	logic [RW-1:0]  h_m1_q, fr_h_m1, cur_h_m1;
	logic [EXW-1:0] ax_q, dx_q, fr_ax, fr_dx, cur_ax, cur_dx;
	logic [EYW-1:0] ay_q, dy_q, fr_ay, fr_dy, cur_ay, cur_dy;

	logic [RW-1:0] in_row_q, in_row_n, out_row_q, out_row_n;
	logic [CW-1:0] in_col_q, in_col_n, out_col_q, out_col_n;
	logic [SW-1:0] in_slot_q, in_slot_n, out_slot_q, out_slot_n;
	logic          done_q, done_n, active_q, active_n;
	logic [DW-1:0] dprev_q, dark_gap;

	logic            take, emit, last;
	logic [CW-1:0]   c1;
	logic [DW-1:0]   span;
	logic [RING-1:0] mask;

	// register clamping
	always_comb begin
		int w_i, h_i, ew_i, eh_i, ax_i, ay_i;
		w_i  = (image_width == '0) ? 1 :
			((int'(image_width) > MAX_WIDTH) ? MAX_WIDTH : int'(image_width));
		h_i  = (image_height == '0) ? 1 :
			((int'(image_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(image_height));
		ew_i = (elem_width == '0) ? 1 :
			((int'(elem_width) > MAX_ELEM_W) ? MAX_ELEM_W : int'(elem_width));
		eh_i = (elem_height == '0) ? 1 :
			((int'(elem_height) > MAX_ELEM_H) ? MAX_ELEM_H : int'(elem_height));
		ax_i = (int'(anchor_x) < ew_i - 1) ? int'(anchor_x) : ew_i - 1;
		ay_i = (int'(anchor_y) < eh_i - 1) ? int'(anchor_y) : eh_i - 1;
		fr_w_m1 = CW'(w_i - 1);
		fr_h_m1 = RW'(h_i - 1);
		fr_ax   = EXW'(ax_i);
		fr_dx   = EXW'(ew_i - 1 - ax_i);
		fr_ay   = EYW'(ay_i);
		fr_dy   = EYW'(eh_i - 1 - ay_i);
	end

	// a frame's first pixel already runs on the new geometry
	assign cur_w_m1 = active_q ? w_m1_q : fr_w_m1;
	assign cur_h_m1 = active_q ? h_m1_q : fr_h_m1;
	assign cur_ax   = active_q ? ax_q   : fr_ax;
	assign cur_dx   = active_q ? dx_q   : fr_dx;
	assign cur_ay   = active_q ? ay_q   : fr_ay;
	assign cur_dy   = active_q ? dy_q   : fr_dy;

	assign take = accept && (kind == KIND_PIXEL) && !done_q;

	// running distance back to the last dark pixel of the row, saturating
	always_comb begin
		if (pixel_value < DARK_LIMIT) begin
			dark_gap = '0;
		end else if (in_col_q == '0 || dprev_q == DSAT) begin
			dark_gap = DSAT;
		end else begin
			dark_gap = dprev_q + DW'(1);
		end
	end

	assign wr_en   = take;
	assign wr_slot = in_slot_q;
	assign wr_col  = in_col_q;
	assign wr_pix  = pixel_value;
	assign wr_dist = dark_gap;

	always_comb begin
		int cw, ch, ir, ic, is, orow, ocol, nr, nc, a, c0, nrows, r0s, rel;
		logic rdy;
		cw = int'(cur_w_m1) + 1;
		ch = int'(cur_h_m1) + 1;
		ir = int'(in_row_q);
		ic = int'(in_col_q);
		is = int'(in_slot_q);
		done_n = done_q;
		if (take) begin
			if (ic + 1 >= cw) begin
				ic = 0;
				ir = ir + 1;
				is = (is + 1 == RING) ? 0 : is + 1;
				if (ir >= ch) begin
					done_n = 1'b1;
				end
			end else begin
				ic = ic + 1;
			end
		end
		orow = int'(out_row_q);
		ocol = int'(out_col_q);
		nr = (orow + int'(cur_dy) > ch - 1) ? ch - 1 : orow + int'(cur_dy);
		nc = (ocol + int'(cur_dx) > cw - 1) ? cw - 1 : ocol + int'(cur_dx);
		rdy = done_n || (nr < ir) || (nr == ir && nc < ic);
		emit = take ? rdy : (accept && done_q);
		a  = (orow < int'(cur_ay)) ? orow : int'(cur_ay);
		c0 = ocol - ((ocol < int'(cur_ax)) ? ocol : int'(cur_ax));
		nrows = nr - orow + a + 1;
		r0s = int'(out_slot_q) - a;
		if (r0s < 0) begin
			r0s = r0s + RING;
		end
		for (int b = 0; b < RING; b++) begin
			rel = b - r0s;
			if (rel < 0) begin
				rel = rel + RING;
			end
			mask[b] = (rel < nrows);
		end
		c1   = CW'(nc);
		span = DW'(nc - c0);
		last = (orow == ch - 1) && (ocol == cw - 1);

		in_row_n   = RW'(ir);
		in_col_n   = CW'(ic);
		in_slot_n  = SW'(is);
		out_row_n  = out_row_q;
		out_col_n  = out_col_q;
		out_slot_n = out_slot_q;
		active_n   = active_q || take;
		if (emit) begin
			if (ocol + 1 >= cw) begin
				out_col_n  = '0;
				out_row_n  = out_row_q + RW'(1);
				out_slot_n = (int'(out_slot_q) == RING - 1) ? '0 : out_slot_q + SW'(1);
			end else begin
				out_col_n = out_col_q + CW'(1);
			end
		end
		if (emit && last) begin
			in_row_n   = '0;
			in_col_n   = '0;
			in_slot_n  = '0;
			out_row_n  = '0;
			out_col_n  = '0;
			out_slot_n = '0;
			done_n     = 1'b0;
			active_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_slot_q <= '0;
			done_q     <= 1'b0;
			active_q   <= 1'b0;
			dprev_q    <= '0;
			w_m1_q     <= '0;
			h_m1_q     <= '0;
			ax_q       <= '0;
			dx_q       <= '0;
			ay_q       <= '0;
			dy_q       <= '0;
			req_s1     <= '0;
		end else begin
			in_row_q   <= in_row_n;
			in_col_q   <= in_col_n;
			in_slot_q  <= in_slot_n;
			out_row_q  <= out_row_n;
			out_col_q  <= out_col_n;
			out_slot_q <= out_slot_n;
			done_q     <= done_n;
			active_q   <= active_n;
			if (take) begin
				dprev_q <= dark_gap;
			end
			if (take && !active_q) begin
				w_m1_q <= fr_w_m1;
				h_m1_q <= fr_h_m1;
				ax_q   <= fr_ax;
				dx_q   <= fr_dx;
				ay_q   <= fr_ay;
				dy_q   <= fr_dy;
			end
			req_s1.valid <= emit;
			req_s1.last  <= emit && last;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rd_slot_s1 <= out_slot_q;
			rd_col_s1  <= out_col_q;
			rd_c1_s1   <= c1;
			rd_span_s1 <= span;
			rd_mask_s1 <= mask;
		end
	end

endmodule

// ===== rtl/core/tdr_eval.sv =====
// Pixel ring store, banked dark-distance store and window evaluation.
module tdr_eval import tdr_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_ELEM_W = DEF_MAX_ELEM_W,
	parameter int MAX_ELEM_H = DEF_MAX_ELEM_H,
	localparam int CW   = $clog2(MAX_WIDTH),
	localparam int RING = MAX_ELEM_H + 1,
	localparam int SW   = $clog2(RING),
	localparam int DW   = $clog2(MAX_ELEM_W + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [SW-1:0]   wr_slot,
	input  logic [CW-1:0]   wr_col,
	input  logic [7:0]      wr_pix,
	input  logic [DW-1:0]   wr_dist,
	input  tdr_req_t        req_s1,
	input  logic [SW-1:0]   rd_slot_s1,
	input  logic [CW-1:0]   rd_col_s1,
	input  logic [CW-1:0]   rd_c1_s1,
	input  logic [DW-1:0]   rd_span_s1,
	input  logic [RING-1:0] rd_mask_s1,
	output logic            res_valid,
	output logic            res_last,
	output logic [7:0]      res_pixel
);

	localparam int PDEPTH = RING * MAX_WIDTH;
	localparam int PAW    = $clog2(PDEPTH);

	logic [PAW-1:0]  pix_waddr, pix_raddr;
	logic [7:0]      pix_s2;
	logic [DW-1:0]   dist_s2 [RING];
	tdr_req_t        req_s2;
	logic [DW-1:0]   span_s2;
	logic [RING-1:0] mask_s2;
	logic            dark;

	assign pix_waddr = PAW'(wr_slot) * PAW'(MAX_WIDTH) + PAW'(wr_col);
	assign pix_raddr = PAW'(rd_slot_s1) * PAW'(MAX_WIDTH) + PAW'(rd_col_s1);

	tdr_ram #(.WIDTH(8), .DEPTH(PDEPTH)) u_pix_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pix_waddr),
		.wdata (wr_pix),
		.raddr (pix_raddr),
		.rdata (pix_s2)
	);

	// one bank per ring row, all read at the window's right column
	for (genvar b = 0; b < RING; b++) begin : g_bank
		tdr_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_dist_ram (
			.clk   (clk),
			.we    (wr_en && (wr_slot == SW'(b))),
			.waddr (wr_col),
			.wdata (wr_dist),
			.raddr (rd_c1_s1),
			.rdata (dist_s2[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2 <= '0;
		end else begin
			req_s2 <= req_s1;
		end
	end

	always_ff @(posedge clk) begin
		span_s2 <= rd_span_s1;
		mask_s2 <= rd_mask_s1;
	end

	always_comb begin
		dark = 1'b0;
		for (int b = 0; b < RING; b++) begin
			if (mask_s2[b] && (dist_s2[b] <= span_s2)) begin
				dark = 1'b1;
			end
		end
	end

	assign res_valid = req_s2.valid;
	assign res_last  = req_s2.last;
	assign res_pixel = dark ? 8'd0 : pix_s2;

endmodule
